// ===== rtl/i2cm_pkg.sv =====
// i2cm_pkg: payload structs, command codes and constants for the I2C master
// bit engine. No dependencies.
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_WIDTH     = 8;
  localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 8'd10;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_WAIT  = 3'd4;
  localparam logic [2:0] MODE_ACK   = 3'd5;
  localparam logic [2:0] MODE_NACK  = 3'd6;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } out_item_t;

  // classified tick as it sits in the queue
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // index of the last delayed phase of each command
  function automatic logic [1:0] last_phase(input logic [2:0] cmd);
    logic [1:0] lp;
    case (cmd)
      MODE_STOP: lp = 2'd0;
      MODE_READ: lp = 2'd1;
      default:   lp = 2'd2;
    endcase
    return lp;
  endfunction

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// i2c_master_bit_engine: top level of the I2C master line sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_seq.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one beat per clock tick of
//   the line sequencer, carrying an optional command and the sampled SDA.
//   Result channel (out_valid/out_stall/out_data): exactly one beat per
//   input beat, in order, showing SCL/SDA drive, busy, done, the last read
//   byte and the acknowledge bit after that tick.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes delay_ticks;
//   cfg_ready is always high. Write it only while the engine is idle.
//   Throughput: one beat per cycle while out_stall is low. An accepted
//   input beat is first written into the queue; when it is popped, the
//   sequencer steps and the output register loads, raising out_valid.
//   When out_stall is high the result holds; the queue of QUEUE_DEPTH
//   beats keeps taking input until it fills, then in_stall rises.
//   Reset (rst_n low, synchronous): queue empty, no result valid, lines
//   released, not busy, delay_ticks = 10.
module i2c_master_bit_engine import i2cm_pkg::*; #(
  parameter int DELAY_WIDTH = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  q_status_t q_status;
  q_entry_t  push_entry, head;
  logic      push, pop;

  i2cm_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  i2cm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  i2cm_seq #(.DELAY_WIDTH(DELAY_WIDTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/i2cm_front.sv =====
// i2cm_front: input handshake and command classification.
// Depends on i2cm_pkg.
module i2cm_front import i2cm_pkg::*; (
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output q_entry_t  push_entry
);

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_entry.is_cmd  = in_data.cmd_valid && (in_data.mode <= MODE_NACK);
    push_entry.mode    = in_data.mode;
    push_entry.tx_byte = in_data.tx_byte;
    push_entry.sda_in  = in_data.sda_in;
  end

endmodule

// ===== rtl/i2cm_queue.sv =====
// i2cm_queue: small register FIFO between classifier and sequencer.
// Depends on i2cm_pkg.
module i2cm_queue import i2cm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == FULL);
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/i2cm_seq.sv =====
// i2cm_seq: bus phase sequencer, delay register and result register.
// Depends on i2cm_pkg.
module i2cm_seq import i2cm_pkg::*; #(
  parameter int DELAY_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  input  q_entry_t             head,
  input  q_status_t            q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int DW = DELAY_WIDTH;
  localparam logic [DW-1:0] ONE = DW'(1);

  logic [DW+CFG_WIDTH-1:0] cfg_ext, rst_ext;
  logic [DW-1:0] delay_r, delay_nxt, dly;
  logic [DW-1:0] tick_r, tick_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [1:0]    phase_r, phase_nxt, ep;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic          scl_r, scl_nxt, sda_r, sda_nxt, busy_r, busy_nxt;
  logic          ack_r, ack_nxt, done, do_enter, fin;
  logic          out_valid_r;
  out_item_t     out_r;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = {{DW{1'b0}}, cfg_data};
  assign rst_ext   = {{DW{1'b0}}, DELAY_RESET};
  assign delay_nxt = (cfg_valid && cfg_ready) ? cfg_ext[DW-1:0] : delay_r;
  assign dly       = (delay_r == '0) ? ONE : delay_r;

  assign pop       = !q_status.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    tick_nxt  = tick_r;
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    rd_nxt    = rd_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    busy_nxt  = busy_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    do_enter  = 1'b0;
    fin       = 1'b0;
    ep        = 2'd0;
    if (pop) begin
      if (busy_r) begin
        if (tick_r < dly) begin
          tick_nxt = tick_r + 1'b1;
        end else begin
          if (cmd_r == MODE_READ && phase_r == 2'd0) begin
            shift_nxt = {shift_r[6:0], head.sda_in};
          end
          if (cmd_r == MODE_WAIT && phase_r == 2'd1) begin
            ack_nxt = head.sda_in;
          end
          if (phase_r < last_phase(cmd_r)) begin
            do_enter = 1'b1;
            ep       = phase_r + 1'b1;
          end else begin
            fin = 1'b1;
            if (cmd_r == MODE_WRITE || cmd_r == MODE_READ) begin
              bit_nxt = bit_r + 1'b1;
              if (bit_nxt < 4'(BITS_PER_BYTE)) begin
                fin      = 1'b0;
                do_enter = 1'b1;
              end else if (cmd_r == MODE_READ) begin
                rd_nxt = shift_nxt;
              end
            end
            if (fin) begin
              if (cmd_r == MODE_STOP || cmd_r == MODE_ACK) begin
                sda_nxt = 1'b1;
              end
              busy_nxt  = 1'b0;
              done      = 1'b1;
              phase_nxt = 2'd0;
              tick_nxt  = '0;
            end
          end
        end
      end else if (head.is_cmd) begin
        cmd_nxt   = head.mode;
        busy_nxt  = 1'b1;
        bit_nxt   = 4'd0;
        shift_nxt = (head.mode == MODE_WRITE) ? head.tx_byte : 8'd0;
        do_enter  = 1'b1;
      end
      if (do_enter) begin
        phase_nxt = ep;
        tick_nxt  = ONE;
        case (cmd_nxt)
          MODE_START: begin
            if (ep == 2'd0) begin
              sda_nxt = 1'b1;
              scl_nxt = 1'b1;
            end else if (ep == 2'd1) begin
              sda_nxt = 1'b0;
            end else begin
              scl_nxt = 1'b0;
            end
          end
          MODE_STOP: begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end
          MODE_WRITE: begin
            if (ep == 2'd0) begin
              sda_nxt = shift_nxt[7];
            end else if (ep == 2'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
              if (bit_nxt == 4'(BITS_PER_BYTE - 1)) begin
                sda_nxt = 1'b1;
              end
              shift_nxt = {shift_nxt[6:0], 1'b0};
            end
          end
          MODE_READ: begin
            scl_nxt = (ep == 2'd0);
          end
          MODE_WAIT, MODE_NACK: begin
            if (ep == 2'd0) begin
              sda_nxt = 1'b1;
            end else if (ep == 2'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end
          default: begin
            if (ep == 2'd0) begin
              sda_nxt = 1'b0;
            end else if (ep == 2'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= rst_ext[DW-1:0];
      tick_r      <= '0;
      cmd_r       <= MODE_START;
      phase_r     <= 2'd0;
      bit_r       <= 4'd0;
      shift_r     <= 8'd0;
      rd_r        <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      busy_r      <= 1'b0;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      delay_r     <= delay_nxt;
      tick_r      <= tick_nxt;
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      rd_r        <= rd_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      busy_r      <= busy_nxt;
      ack_r       <= ack_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.scl_out  <= scl_nxt;
      out_r.sda_out  <= sda_nxt;
      out_r.busy_res <= busy_nxt;
      out_r.done_res <= done;
      out_r.rx_byte  <= rd_nxt;
      out_r.ack_bit  <= ack_nxt;
    end
  end

endmodule

// ===== rtl/i2cm_checker.sv =====
// i2cm_checker: port-level checks for i2c_master_bit_engine, bound to it.
// Depends on i2cm_pkg.
module i2cm_checker import i2cm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done with busy still set");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for i2c_master_bit_engine, one tick per beat, with
// random gaps and stalls, a line-sequencer predictor and in-order result check.
// Depends on i2cm_pkg and the i2c_master_bit_engine RTL.
module tb_top;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_NONE = 3'd7;
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  in_item_t  tick_q[$];
  out_item_t line_q[$];
  logic      in_taken = 1'b0;
  bit        calm = 1'b0;
  int        mismatches = 0;
  int        ticks_queued = 0;

  // predictor state
  logic [2:0] p_cmd = '0;
  logic [2:0] p_phase = '0;
  logic [7:0] p_count = '0;
  logic [3:0] p_bit = '0;
  logic [7:0] p_shift = '0;
  logic       p_scl = 1'b1;
  logic       p_sda = 1'b1;
  logic       p_busy = 1'b0;
  logic [7:0] p_rx = '0;
  logic       p_ack = 1'b0;
  logic [7:0] p_delay = DELAY_RESET;

  i2c_master_bit_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [2:0] closing_phase(input logic [2:0] c);
    logic [2:0] lp;
    case (c)
      MODE_STOP: lp = 3'd0;
      MODE_READ: lp = 3'd1;
      default:   lp = 3'd2;
    endcase
    return lp;
  endfunction

  function automatic void enter_step(input logic [2:0] p);
    p_phase = p;
    p_count = 8'd1;
    case (p_cmd)
      MODE_START: begin
        if (p == 3'd0) begin
          p_sda = 1'b1;
          p_scl = 1'b1;
        end else if (p == 3'd1) p_sda = 1'b0;
        else p_scl = 1'b0;
      end
      MODE_STOP: begin
        p_sda = 1'b0;
        p_scl = 1'b1;
      end
      MODE_WRITE: begin
        if (p == 3'd0) p_sda = p_shift[7];
        else if (p == 3'd1) p_scl = 1'b1;
        else begin
          p_scl = 1'b0;
          if (p_bit == BITS_PER_BYTE - 1) p_sda = 1'b1;
          p_shift = {p_shift[6:0], 1'b0};
        end
      end
      MODE_READ: p_scl = (p == 3'd0);
      MODE_WAIT, MODE_NACK: begin
        if (p == 3'd0) p_sda = 1'b1;
        else if (p == 3'd1) p_scl = 1'b1;
        else p_scl = 1'b0;
      end
      default: begin
        if (p == 3'd0) p_sda = 1'b0;
        else if (p == 3'd1) p_scl = 1'b1;
        else p_scl = 1'b0;
      end
    endcase
  endfunction

  // returns 1 when the running command completes on this tick
  function automatic logic leave_step(input logic sda);
    if (p_cmd == MODE_READ && p_phase == 3'd0) p_shift = {p_shift[6:0], sda};
    if (p_cmd == MODE_WAIT && p_phase == 3'd1) p_ack = sda;
    if (p_phase < closing_phase(p_cmd)) begin
      enter_step(p_phase + 3'd1);
      return 1'b0;
    end
    if (p_cmd == MODE_WRITE || p_cmd == MODE_READ) begin
      p_bit = p_bit + 4'd1;
      if (p_bit < BITS_PER_BYTE) begin
        enter_step(3'd0);
        return 1'b0;
      end
      if (p_cmd == MODE_READ) p_rx = p_shift;
    end
    if (p_cmd == MODE_STOP || p_cmd == MODE_ACK) p_sda = 1'b1;
    return 1'b1;
  endfunction

  function automatic out_item_t line_tick(input in_item_t it);
    logic [7:0] dly;
    logic       fin;
    out_item_t  r;
    dly = (p_delay == 8'd0) ? 8'd1 : p_delay;
    fin = 1'b0;
    if (p_busy) begin
      if (p_count < dly) p_count = p_count + 8'd1;
      else if (leave_step(it.sda_in)) begin
        p_busy = 1'b0;
        fin = 1'b1;
        p_phase = '0;
        p_count = '0;
      end
    end else if (it.cmd_valid && it.mode <= MODE_NACK) begin
      p_cmd = it.mode;
      p_busy = 1'b1;
      p_bit = '0;
      p_shift = (it.mode == MODE_WRITE) ? it.tx_byte : 8'd0;
      enter_step(3'd0);
    end
    r.scl_out = p_scl;
    r.sda_out = p_sda;
    r.busy_res = p_busy;
    r.done_res = fin;
    r.rx_byte = p_rx;
    r.ack_bit = p_ack;
    return r;
  endfunction

  function automatic string fmt_line(input out_item_t r);
    return $sformatf("scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                     r.scl_out, r.sda_out, r.busy_res, r.done_res, r.rx_byte, r.ack_bit);
  endfunction

  // input side: predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      line_q.push_back(line_tick(in_data));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
        in_data <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 12);
  end

  // result side
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        mismatches <= mismatches + 1;
        $display("%0t: expected no beat, got %s", $time, fmt_line(out_data));
      end else begin
        e = line_q.pop_front();
        if (out_data !== e) begin
          mismatches <= mismatches + 1;
          $display("%0t: expected %s, got %s", $time, fmt_line(e), fmt_line(out_data));
        end
      end
    end
  end

  task automatic push_tick(input logic cv, input logic [2:0] md, input logic [7:0] tx,
                           input logic sda);
    in_item_t it;
    it.cmd_valid = cv;
    it.mode = md;
    it.tx_byte = tx;
    it.sda_in = sda;
    tick_q.push_back(it);
    ticks_queued++;
  endtask

  function automatic int command_ticks(input logic [2:0] md);
    int steps;
    int dly;
    dly = (p_delay == 8'd0) ? 1 : int'(p_delay);
    case (md)
      MODE_STOP:  steps = 1;
      MODE_WRITE: steps = 3 * BITS_PER_BYTE;
      MODE_READ:  steps = 2 * BITS_PER_BYTE;
      default:    steps = 3;
    endcase
    return steps * dly + 1;
  endfunction

  // one command beat followed by the ticks it runs for; noise is ignored commands
  task automatic queue_command(input logic [2:0] md, input logic [7:0] tx, input int sda_sel,
                               input int noise_pct);
    int   n;
    logic s;
    n = (md > MODE_NACK) ? 1 : command_ticks(md);
    for (int i = 0; i < n; i++) begin
      s = (sda_sel == SDA_RAND) ? 1'($urandom_range(1)) : (sda_sel == SDA_HIGH);
      if (i == 0) push_tick(1'b1, md, tx, s);
      else push_tick($urandom_range(99) < noise_pct, 3'($urandom_range(7)), 8'($urandom), s);
    end
  endtask

  task automatic bus_transfer();
    queue_command(MODE_START, 8'($urandom), SDA_RAND, 10);
    queue_command(MODE_WRITE, 8'($urandom), SDA_RAND, 10);
    queue_command(MODE_WAIT, 8'($urandom), SDA_RAND, 10);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1)) begin
        queue_command(MODE_WRITE, 8'($urandom), SDA_RAND, 10);
        queue_command(MODE_WAIT, 8'($urandom), SDA_RAND, 10);
      end else begin
        queue_command(MODE_READ, 8'($urandom), SDA_RAND, 10);
        queue_command($urandom_range(1) ? MODE_ACK : MODE_NACK, 8'($urandom), SDA_RAND, 10);
      end
    end
    queue_command(MODE_STOP, 8'($urandom), SDA_RAND, 10);
  endtask

  task automatic random_traffic(input int budget);
    int first;
    first = ticks_queued;
    while (ticks_queued - first < budget) begin
      if ($urandom_range(99) < 80) bus_transfer();
      else queue_command(3'($urandom_range(7)), 8'($urandom), SDA_RAND, 30);
      repeat ($urandom_range(2))
        push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  task automatic drain();
    forever begin
      while (tick_q.size() != 0 || in_valid || line_q.size() != 0) @(posedge clk);
      if (!p_busy) break;
      repeat (8) push_tick(1'b0, MODE_START, 8'd0, 1'b1);
    end
  endtask

  task automatic set_delay(input logic [7:0] v);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    p_delay = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset delay
    queue_command(MODE_START, 8'h00, SDA_HIGH, 0);
    queue_command(MODE_WAIT, 8'h00, SDA_LOW, 0);
    queue_command(MODE_STOP, 8'h00, SDA_RAND, 0);

    // directed, shortest delay
    set_delay(8'd1);
    queue_command(MODE_START, 8'h00, SDA_HIGH, 0);
    queue_command(MODE_WRITE, 8'hFF, SDA_HIGH, 0);
    queue_command(MODE_WAIT, 8'h00, SDA_LOW, 0);
    queue_command(MODE_WRITE, 8'h00, SDA_LOW, 0);
    queue_command(MODE_WAIT, 8'h00, SDA_HIGH, 0);
    queue_command(MODE_READ, 8'h00, SDA_HIGH, 0);
    queue_command(MODE_ACK, 8'h00, SDA_RAND, 0);
    queue_command(MODE_READ, 8'hFF, SDA_LOW, 0);
    queue_command(MODE_NACK, 8'h00, SDA_RAND, 0);
    queue_command(MODE_NONE, 8'h5A, SDA_RAND, 0);
    queue_command(MODE_READ, 8'h00, SDA_RAND, 0);
    queue_command(MODE_STOP, 8'h00, SDA_RAND, 0);
    queue_command(MODE_WRITE, 8'hA5, SDA_RAND, 100);
    queue_command(MODE_STOP, 8'h00, SDA_RAND, 100);
    drain();

    calm = 1'b1;
    random_traffic(250);
    drain();
    calm = 1'b0;

    set_delay(8'd0);
    random_traffic(150);
    set_delay(8'd2);
    random_traffic(150);

    set_delay(8'd255);
    queue_command(MODE_STOP, 8'h00, SDA_RAND, 5);

    set_delay(8'd3);
    random_traffic(100);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && line_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_queue.sv
rtl/i2cm_seq.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_checker.sv
sim/tb_top.sv
